FILE: hdl/bcs_pkg.sv
package bcs_pkg;

	localparam int unsigned IN_W  = 32;
	localparam int unsigned ACC_W = 64;

endpackage

FILE: hdl/bcs_div.sv
module bcs_div #(
	parameter int unsigned W = bcs_pkg::ACC_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] dividend,
	input  logic [W-1:0] divisor,
	output logic         done,
	output logic [W-1:0] quot,
	output logic [W-1:0] rem
);
	localparam int unsigned CNT_W = $clog2(W + 1);

	logic [W-1:0]     rem_q;
	logic [W-1:0]     quo_q;
	logic [W-1:0]     dvs_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [W:0]       r2;
	logic             ge;
	logic [W:0]       diff;

	// restoring division, one quotient bit per cycle
	assign r2   = {rem_q, quo_q[W-1]};
	assign ge   = r2 >= {1'b0, dvs_q};
	assign diff = r2 - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[W-1:0] : r2[W-1:0];
			quo_q <= {quo_q[W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem  = rem_q;

endmodule

FILE: hdl/binomial_coefficient_saturating.sv
// for invalid inputs a 0 result goes from idle straight to the output state; otherwise each
// term costs several bit-serial divisions (one per euclid step, cancellation and overflow
// test) plus a shift-add multiply of the accumulator
// throughput: one transaction at a time; the shared serial divider sets the pace
// reset: arst_n asynchronous active low, returns to idle with no result pending
module binomial_coefficient_saturating #(
	parameter int unsigned DATA_W = bcs_pkg::ACC_W
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic signed [bcs_pkg::IN_W-1:0]   set_size,
	input  logic signed [bcs_pkg::IN_W-1:0]   choose_count,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic        [DATA_W-1:0]          coefficient
);
	import bcs_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_TERM = 5'd1;
	localparam logic [4:0] S_G1   = 5'd2;
	localparam logic [4:0] S_G1W  = 5'd3;
	localparam logic [4:0] S_A1   = 5'd4;
	localparam logic [4:0] S_D1   = 5'd5;
	localparam logic [4:0] S_G2   = 5'd6;
	localparam logic [4:0] S_G2W  = 5'd7;
	localparam logic [4:0] S_N2   = 5'd8;
	localparam logic [4:0] S_D2   = 5'd9;
	localparam logic [4:0] S_CHK  = 5'd10;
	localparam logic [4:0] S_ND   = 5'd11;
	localparam logic [4:0] S_OV   = 5'd12;
	localparam logic [4:0] S_OVW  = 5'd13;
	localparam logic [4:0] S_MUL  = 5'd14;
	localparam logic [4:0] S_NEXT = 5'd15;
	localparam logic [4:0] S_OUT  = 5'd16;

	localparam logic [DATA_W-1:0] SAT = '1;
	localparam logic [DATA_W-1:0] ONE = DATA_W'(1);

	logic [4:0]        state_q;
	logic [IN_W-1:0]   r_q;
	logic [IN_W-1:0]   base_q;
	logic [IN_W-1:0]   k_q;
	logic [DATA_W-1:0] acc_q;
	logic [DATA_W-1:0] num_q;
	logic [DATA_W-1:0] den_q;
	logic [DATA_W-1:0] gx_q;
	logic [DATA_W-1:0] gy_q;
	logic [DATA_W-1:0] g_q;
	logic [DATA_W-1:0] mul_a_q;
	logic [DATA_W-1:0] mul_b_q;
	logic [DATA_W-1:0] prod_q;
	logic [DATA_W-1:0] res_q;
	logic [DATA_W-1:0] coef_q;
	logic              out_valid_q;
	logic              div_start_q;
	logic [DATA_W-1:0] div_a_q;
	logic [DATA_W-1:0] div_b_q;
	logic              div_done;
	logic [DATA_W-1:0] div_quot;
	logic [DATA_W-1:0] div_rem;

	logic              accept;
	logic              invalid;
	logic [IN_W-1:0]   nmr;
	logic [IN_W-1:0]   rsel;
	logic [IN_W-1:0]   term_num;

	assign accept   = in_valid && (state_q == S_IDLE);
	assign invalid  = set_size[IN_W-1] || choose_count[IN_W-1] || (choose_count > set_size);
	assign nmr      = $unsigned(set_size) - $unsigned(choose_count);
	assign rsel     = ($unsigned(choose_count) > nmr) ? nmr : $unsigned(choose_count);
	assign term_num = base_q + k_q;

	bcs_div #(.W(DATA_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start_q),
		.dividend (div_a_q),
		.divisor  (div_b_q),
		.done     (div_done),
		.quot     (div_quot),
		.rem      (div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_valid_q && !out_stall && (state_q != S_OUT))
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (accept) state_q <= invalid ? S_OUT : S_TERM;
				S_TERM: state_q <= (k_q > r_q) ? S_OUT : S_G1;
				S_G1: begin
					div_start_q <= 1'b1;
					state_q     <= (gy_q == '0) ? S_A1 : S_G1W;
				end
				S_G1W: if (div_done) state_q <= S_G1;
				S_A1: if (div_done) begin
					div_start_q <= 1'b1;
					state_q     <= S_D1;
				end
				S_D1: if (div_done) state_q <= S_G2;
				S_G2: begin
					div_start_q <= 1'b1;
					state_q     <= (gy_q == '0) ? S_N2 : S_G2W;
				end
				S_G2W: if (div_done) state_q <= S_G2;
				S_N2: if (div_done) begin
					div_start_q <= 1'b1;
					state_q     <= S_D2;
				end
				S_D2: if (div_done) state_q <= S_CHK;
				S_CHK: begin
					div_start_q <= (den_q != ONE);
					state_q     <= (den_q != ONE) ? S_ND : S_OV;
				end
				S_ND: if (div_done) state_q <= (div_rem != '0) ? S_OUT : S_OV;
				S_OV: begin
					div_start_q <= (num_q != ONE);
					state_q     <= (num_q != ONE) ? S_OVW : S_NEXT;
				end
				S_OVW: if (div_done) state_q <= (acc_q > div_quot) ? S_OUT : S_MUL;
				S_MUL: if (mul_b_q == '0) state_q <= S_NEXT;
				S_NEXT: state_q <= S_TERM;
				S_OUT: if (!out_valid_q || !out_stall) begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q) inside
			S_IDLE: begin
				res_q  <= '0;
				acc_q  <= ONE;
				k_q    <= IN_W'(1);
				r_q    <= rsel;
				base_q <= $unsigned(set_size) - rsel;
			end
			S_TERM: begin
				res_q <= acc_q;
				num_q <= DATA_W'(term_num);
				den_q <= DATA_W'(k_q);
				gx_q  <= acc_q;
				gy_q  <= DATA_W'(k_q);
			end
			S_G1, S_G2: begin
				g_q     <= gx_q;
				div_a_q <= (gy_q == '0) ? ((state_q == S_G1) ? acc_q : num_q) : gx_q;
				div_b_q <= (gy_q == '0) ? gx_q : gy_q;
			end
			S_G1W, S_G2W: if (div_done) begin
				gx_q <= gy_q;
				gy_q <= div_rem;
			end
			S_A1: if (div_done) begin
				acc_q   <= div_quot;
				div_a_q <= den_q;
				div_b_q <= g_q;
			end
			S_D1: if (div_done) begin
				den_q <= div_quot;
				gx_q  <= num_q;
				gy_q  <= div_quot;
			end
			S_N2: if (div_done) begin
				num_q   <= div_quot;
				div_a_q <= den_q;
				div_b_q <= g_q;
			end
			S_D2: if (div_done) den_q <= div_quot;
			S_CHK: begin
				div_a_q <= num_q;
				div_b_q <= den_q;
			end
			S_ND: if (div_done) begin
				if (div_rem != '0)
					res_q <= SAT;
				else
					num_q <= div_quot;
			end
			S_OV: begin
				div_a_q <= SAT;
				div_b_q <= num_q;
			end
			S_OVW: if (div_done) begin
				res_q   <= SAT;
				mul_a_q <= acc_q;
				mul_b_q <= num_q;
				prod_q  <= '0;
			end
			// shift-add, one multiplier bit per cycle; fits since overflow was ruled out
			S_MUL: begin
				if (mul_b_q == '0) begin
					acc_q <= prod_q;
				end else begin
					if (mul_b_q[0])
						prod_q <= prod_q + mul_a_q;
					mul_a_q <= {mul_a_q[DATA_W-2:0], 1'b0};
					mul_b_q <= {1'b0, mul_b_q[DATA_W-1:1]};
				end
			end
			S_NEXT: k_q <= k_q + 1'b1;
			S_OUT: if (!out_valid_q || !out_stall) coef_q <= res_q;
			default: ;
		endcase
	end

	assign in_stall    = (state_q != S_IDLE);
	assign out_valid   = out_valid_q;
	assign coefficient = coef_q;

endmodule

FILE: hdl/bcs_chk.sv
module bcs_chk #(
	parameter int unsigned DATA_W = bcs_pkg::ACC_W
) (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [DATA_W-1:0] coefficient
);
	// a held result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(coefficient))
		else $error("result changed while stalled");

	// one transaction in flight: busy right after accepting
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken while computing");

	// a new result only comes out of a computation
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a transaction");

endmodule

bind binomial_coefficient_saturating bcs_chk #(.DATA_W(DATA_W)) u_bcs_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.coefficient (coefficient)
);
